// ===== rtl/modexp_pkg.sv =====
// Shared types and constants for the modular exponentiation block.
// No dependencies; imported by modular_exponentiation.
`default_nettype none

package modexp_pkg;

  // Default field widths
  localparam int unsigned ModulusBitsDef  = 31;
  localparam int unsigned ExponentBitsDef = 32;

  // Modulus after reset: 10^9 + 7
  localparam logic [30:0] ModulusReset = 31'd1000000007;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,    // waiting for an input transaction
    ST_REDUCE,  // base mod m through the shared unit
    ST_CHECK,   // pick the next operation from the exponent
    ST_MUL,     // acc * base mod m
    ST_SQR,     // base * base mod m
    ST_FIN      // hand the result to the output register
  } modexp_state_e;

endpackage

`default_nettype wire

// ===== rtl/modular_exponentiation.sv =====
// Modular exponentiation top level: right-to-left square-and-multiply
// around one bit-serial modular multiplier. Depends on modexp_pkg.
//
// Computes base_value ** exponent_value mod the configured modulus (reset
// value 10^9 + 7; a modulus below 2 gives 0). One transaction is worked on
// at a time and in_ready_o is low while it runs. Every modular product goes
// through a single shared shift-add-reduce unit that consumes one multiplier
// bit per cycle, then a decision step picks the next operation. A
// transaction takes the base reduction, then one squaring for each
// exponent bit below the highest set bit and one multiply for each set
// bit, then hands the result to an output register, so the next
// transaction can be accepted while the result waits.
`default_nettype none

module modular_exponentiation
  import modexp_pkg::*;
#(
  parameter int unsigned MODULUS_BITS  = ModulusBitsDef,
  parameter int unsigned EXPONENT_BITS = ExponentBitsDef
) (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  // configuration
  input  wire                      cfg_we_i,
  input  wire [MODULUS_BITS-1:0]   cfg_wdata_i,
  // input channel
  input  wire                      in_valid_i,
  output logic                     in_ready_o,
  input  wire [MODULUS_BITS-1:0]   base_value_i,
  input  wire [EXPONENT_BITS-1:0]  exponent_value_i,
  // output channel
  output logic                     out_valid_o,
  input  wire                      out_ready_i,
  output logic [MODULUS_BITS-1:0]  power_result_o
);

  localparam int unsigned MB   = MODULUS_BITS;
  localparam int unsigned EB   = EXPONENT_BITS;
  localparam int unsigned CntW = $clog2(MB);
  localparam int unsigned TW   = MB + 2;   // holds 2r + x < 3m

  localparam logic [MB-1:0]   ModResetVal = MB'(ModulusReset);
  localparam logic [CntW-1:0] CntLast     = CntW'(MB - 1);
  localparam logic [MB-1:0]   One         = MB'(1);

  modexp_state_e state_q, state_d;

  logic [MB-1:0]   modulus_q;
  logic [MB-1:0]   acc_q, acc_d;
  logic [MB-1:0]   base_q, base_d;
  logic [EB-1:0]   exp_q, exp_d;
  logic [MB-1:0]   mx_q, mx_d;      // multiplicand, always below m
  logic [MB-1:0]   my_q, my_d;      // multiplier, shifted out MSB first
  logic [MB-1:0]   r_q, r_d;        // partial remainder
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [MB-1:0]   fin_q, fin_d;    // value to hand off in ST_FIN
  logic            out_valid_q, out_valid_d;
  logic [MB-1:0]   out_q, out_d;

  logic            mod_small;
  logic            in_fire;
  logic            out_free;
  logic            unit_busy;
  logic            unit_last;
  logic [TW-1:0]   step_t;
  logic [TW-1:0]   mod1, mod2;
  logic [MB-1:0]   step_r;

  assign mod_small = (modulus_q[MB-1:1] == '0);
  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i & in_ready_o;
  assign out_free   = ~out_valid_q | out_ready_i;
  assign unit_busy  = state_q inside {ST_REDUCE, ST_MUL, ST_SQR};
  assign unit_last  = (cnt_q == '0);

  // Shared unit: one multiplier bit per cycle, r <- (2r + bit*x) mod m
  assign mod1   = {2'b00, modulus_q};
  assign mod2   = {1'b0, modulus_q, 1'b0};
  assign step_t = {1'b0, r_q, 1'b0} + (my_q[MB-1] ? {2'b00, mx_q} : '0);

  always_comb begin
    if (step_t >= mod2) begin
      step_r = MB'(step_t - mod2);
    end else if (step_t >= mod1) begin
      step_r = MB'(step_t - mod1);
    end else begin
      step_r = MB'(step_t);
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          state_d = mod_small ? ST_FIN : ST_REDUCE;
        end
      end
      ST_REDUCE, ST_MUL, ST_SQR: begin
        if (unit_last) begin
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (exp_q == '0) begin
          state_d = ST_FIN;
        end else if (exp_q[0]) begin
          state_d = ST_MUL;
        end else begin
          state_d = ST_SQR;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath and outputs
  always_comb begin
    acc_d       = acc_q;
    base_d      = base_q;
    exp_d       = exp_q;
    mx_d        = mx_q;
    my_d        = my_q;
    r_d         = r_q;
    cnt_d       = cnt_q;
    fin_d       = fin_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    out_d       = out_q;

    // advance the shared unit
    if (unit_busy) begin
      r_d   = step_r;
      my_d  = {my_q[MB-2:0], 1'b0};
      cnt_d = cnt_q - 1'b1;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          // reduce the base as 1 * base mod m
          exp_d = exponent_value_i;
          acc_d = One;
          fin_d = '0;
          mx_d  = One;
          my_d  = base_value_i;
          r_d   = '0;
          cnt_d = CntLast;
        end
      end
      ST_REDUCE: begin
        if (unit_last) begin
          base_d = step_r;
        end
      end
      ST_MUL: begin
        if (unit_last) begin
          acc_d = step_r;
          exp_d = {exp_q[EB-1:1], 1'b0};
        end
      end
      ST_SQR: begin
        if (unit_last) begin
          base_d = step_r;
          exp_d  = {1'b0, exp_q[EB-1:1]};
        end
      end
      ST_CHECK: begin
        fin_d = acc_q;
        r_d   = '0;
        cnt_d = CntLast;
        if (exp_q[0]) begin
          mx_d = acc_q;
          my_d = base_q;
        end else begin
          mx_d = base_q;
          my_d = base_q;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_d       = fin_q;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o    = out_valid_q;
  assign power_result_o = out_q;

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      modulus_q   <= ModResetVal;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        modulus_q <= cfg_wdata_i;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    acc_q  <= acc_d;
    base_q <= base_d;
    exp_q  <= exp_d;
    mx_q   <= mx_d;
    my_q   <= my_d;
    r_q    <= r_d;
    cnt_q  <= cnt_d;
    fin_q  <= fin_d;
    out_q  <= out_d;
  end

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
// Self-checking testbench for modular_exponentiation (square-and-multiply).
// Depends on modexp_pkg and the modular_exponentiation RTL only; it predicts
// every power itself and compares each output transaction in order.
`timescale 1ns / 1ps

module tb
  import modexp_pkg::*;
();

  localparam int unsigned CLK_PERIOD  = 10;
  // Worst case: every transaction at full exponent width plus
  // idling on both sides, taken four times over, plus the long hold-off.
  localparam int unsigned CYCLE_LIMIT = 2000 * 2300 * 4 + 20000;
  localparam int unsigned HOLD_CYCLES = 4000;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [30:0] cfg_wdata_i;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [30:0] base_value_i;
  logic [31:0] exponent_value_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [30:0] power_result_o;

  // Local copy of the modulus register and the powers still owed by the block
  logic [30:0] modulus_q = ModulusReset;
  logic [30:0] expected_powers[$];

  int unsigned tx_idle_pct;
  int unsigned rx_idle_pct;
  int unsigned rx_hold_left;
  int unsigned error_count;
  int unsigned powers_sent;
  int unsigned powers_checked;
  int unsigned modulus_writes;
  int unsigned cycle_count;

  modular_exponentiation uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .base_value_i    (base_value_i),
    .exponent_value_i(exponent_value_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .power_result_o  (power_result_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // base ** exponent mod m, scanning the exponent from bit 0 upward
  function automatic logic [30:0] expected_power(input logic [30:0] base_val,
                                                 input logic [31:0] exp_val,
                                                 input logic [30:0] m);
    logic [63:0] acc;
    logic [63:0] sq;
    logic [63:0] mod64;
    if (m < 31'd2) begin
      return '0;
    end
    mod64 = {33'd0, m};
    acc   = 64'd1;
    sq    = {33'd0, base_val} % mod64;
    for (int i = 0; i < 32; i++) begin
      if (exp_val[i]) begin
        acc = (acc * sq) % mod64;
      end
      sq = (sq * sq) % mod64;
    end
    return acc[30:0];
  endfunction

  // Mostly short exponents to keep the run quick; a few at full width
  function automatic logic [31:0] rand_exponent();
    int unsigned pick;
    int unsigned w;
    logic [31:0] e;
    pick = $urandom_range(99);
    e    = $urandom;
    if (pick < 5) begin
      w = 32;
    end else if (pick < 20) begin
      w = $urandom_range(16, 7);
    end else begin
      w = $urandom_range(6, 0);
    end
    if (w < 32) begin
      e = e & ((32'd1 << w) - 32'd1);
    end
    return e;
  endfunction

  // Small bases, bases around the modulus and the largest base, as well as uniformly random ones
  function automatic logic [30:0] rand_base();
    case ($urandom_range(9))
      0: return 31'($urandom_range(3, 0));
      1: return modulus_q - 31'd1;
      2: return modulus_q;
      3: return 31'h7FFF_FFFF;
      default: return 31'($urandom);
    endcase
  endfunction

  function automatic logic [30:0] pick_modulus();
    case ($urandom_range(9))
      0: return 31'h7FFF_FFFF;
      1: return 31'd2;
      2: return 31'($urandom_range(1000, 3));
      3: return 31'h4000_0000;
      4: return ModulusReset;
      5: return 31'($urandom_range(1, 0));
      default: return 31'($urandom_range(32'h7FFF_FFFF, 2));
    endcase
  endfunction

  // Offer one transaction; entered and left at a falling edge
  task automatic send_operands(input logic [30:0] base_val, input logic [31:0] exp_val);
    if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(negedge clk_i); while ($urandom_range(99) < tx_idle_pct);
    end
    in_valid_i       <= 1'b1;
    base_value_i     <= base_val;
    exponent_value_i <= exp_val;
    do @(posedge clk_i); while (!in_ready_o);
    expected_powers = {expected_powers, expected_power(base_val, exp_val, modulus_q)};
    powers_sent++;
    @(negedge clk_i);
  endtask

  // Stop offering and wait for every owed result, then a short pause
  task automatic drain_pipeline();
    in_valid_i <= 1'b0;
    while (expected_powers.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_modulus(input logic [30:0] m);
    drain_pipeline();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= m;
    @(negedge clk_i);
    cfg_we_i  <= 1'b0;
    modulus_q = m;
    modulus_writes++;
  endtask

  // Edge operands under the modulus left by reset
  task automatic test_reset_modulus();
    send_operands(31'd0, 32'd0);
    send_operands(31'd0, 32'd5);
    send_operands(31'd1, 32'hFFFF_FFFF);
    send_operands(31'h7FFF_FFFF, 32'd0);
    send_operands(31'h7FFF_FFFF, 32'd1);
    send_operands(31'h7FFF_FFFF, 32'hFFFF_FFFF);
    send_operands(31'd2, 32'd30);
    send_operands(ModulusReset, 32'd3);
    send_operands(ModulusReset - 31'd1, 32'd2);
    send_operands(ModulusReset - 31'd1, 32'h8000_0001);
    drain_pipeline();
  endtask

  // Smallest and largest moduli, and the degenerate zero and one
  task automatic test_modulus_extremes();
    write_modulus(31'd2);
    send_operands(31'h7FFF_FFFF, 32'hFFFF_FFFF);
    send_operands(31'd6, 32'd3);
    write_modulus(31'h7FFF_FFFF);
    send_operands(31'h7FFF_FFFF, 32'd1);
    send_operands(31'h7FFF_FFFE, 32'hFFFF_FFFF);
    send_operands(31'd12345, 32'h5555_AAAA);
    write_modulus(31'd0);
    send_operands(31'd5, 32'd0);
    send_operands(31'd7, 32'd9);
    write_modulus(31'd1);
    send_operands(31'd0, 32'd0);
    send_operands(31'h7FFF_FFFF, 32'hFFFF_FFFF);
    drain_pipeline();
  endtask

  // Random operands over several moduli at the given idle rates
  task automatic test_random_traffic(input int unsigned tx_pct, input int unsigned rx_pct,
                                     input int unsigned n_items);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    for (int seg = 0; seg < 5; seg++) begin
      write_modulus(pick_modulus());
      for (int i = 0; i < n_items / 5; i++) begin
        send_operands(rand_base(), rand_exponent());
      end
    end
    drain_pipeline();
  endtask

  // Receiver holds off while the sender keeps offering, so the input stalls
  task automatic test_backpressure();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    write_modulus(31'($urandom_range(32'h7FFF_FFFF, 2)));
    rx_hold_left <= HOLD_CYCLES;
    for (int i = 0; i < 8; i++) begin
      send_operands(31'($urandom), $urandom & 32'h0000_000F);
    end
    drain_pipeline();
  endtask

  // Output side: random or held ready, changed on the falling edge
  always @(negedge clk_i) begin
    out_ready_i <= (rx_hold_left == 0) && ($urandom_range(99) >= rx_idle_pct);
  end

  always @(posedge clk_i) begin
    if (rx_hold_left != 0) begin
      rx_hold_left <= rx_hold_left - 1;
    end
  end

  // Compare every output transaction with the oldest owed power
  always @(posedge clk_i) begin
    logic [30:0] want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      powers_checked++;
      if (expected_powers.size() == 0) begin
        error_count++;
        $display("%0t: unexpected result, expected none, actual %0d", $time,
                 power_result_o);
      end else begin
        want = expected_powers.pop_front();
        if (power_result_o !== want) begin
          error_count++;
          $display("%0t: power_result mismatch, expected %0d, actual %0d", $time,
                   want, power_result_o);
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    rst_ni           = 1'b0;
    cfg_we_i         = 1'b0;
    cfg_wdata_i      = '0;
    in_valid_i       = 1'b0;
    base_value_i     = '0;
    exponent_value_i = '0;
    out_ready_i      = 1'b0;
    tx_idle_pct      = 0;
    rx_idle_pct      = 0;
    rx_hold_left     = 0;
    error_count      = 0;
    powers_sent      = 0;
    powers_checked   = 0;
    modulus_writes   = 0;
    cycle_count      = 0;
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_reset_modulus();
    test_modulus_extremes();
    test_random_traffic(9, 84, 640);
    test_random_traffic(84, 9, 640);
    test_backpressure();
    test_random_traffic(0, 0, 640);

    // Let any stray output show up before closing
    drain_pipeline();
    repeat (2200) @(negedge clk_i);
    if (expected_powers.size() != 0) begin
      error_count++;
      $display("%0t: %0d results never arrived", $time, expected_powers.size());
    end

    $display("Sent %0d transactions, checked %0d results over %0d modulus writes.",
             powers_sent, powers_checked, modulus_writes);
    $display("Covered moduli 0, 1, 2 and 2^31-1, zero and full-width exponents, %0s",
             "both idling mixes and a long output hold-off.");
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
